@@ design/volume_spike_detector_top_defines.svh @@
// Assertion macros for the volume spike detector.
`ifndef VOLUME_SPIKE_DETECTOR_TOP_DEFINES_SVH
`define VOLUME_SPIKE_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTH
`define VSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VSD_ASSERT_IMP(label, ante, cons, msg)
`define VSD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ design/vsd_pkg.sv @@
// Shared types, constants and microcode fields of the volume spike detector.
`timescale 1ns / 1ps
package vsd_pkg;

    localparam int STAMP_W     = 63;
    localparam int VOL_W       = 48;
    localparam int WLEN_W      = 5;
    localparam int FACTOR_W    = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 160;
    localparam int OUT_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_FACTOR  = 1'd1;

    localparam logic [WLEN_W-1:0]   WLEN_RESET   = 5'd10;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd512;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB_OLD,
        ST_ADD_NEW,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_ACC,
        ST_DIV,
        ST_DONE
    } step_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_VOL_LO,
        MUL_VOL_HI,
        MUL_SUM_LO,
        MUL_SUM_HI
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LHS_LOAD,
        ACC_LHS_ADD_HI,
        ACC_RHS_LOAD,
        ACC_RHS_ADD_HI
    } acc_op_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_OUT_FREE,
        COND_DIV_LAST
    } cond_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     load_in;
        logic     sub_old;
        logic     add_new;
        logic     div_init;
        logic     div_step;
        logic     out_load;
        cond_t    cond;
        step_t    target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic div_last;
    } seq_status_t;

    localparam ctrl_word_t CW_NOP = '{
        mul_sel:  MUL_NONE,
        acc_op:   ACC_NONE,
        load_in:  1'b0,
        sub_old:  1'b0,
        add_new:  1'b0,
        div_init: 1'b0,
        div_step: 1'b0,
        out_load: 1'b0,
        cond:     COND_ALWAYS,
        target:   ST_IDLE
    };

endpackage

@@ design/vsd_ring.sv @@
// Volume ring memory with one write port and one registered read port.
`timescale 1ns / 1ps
module vsd_ring #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/vsd_ucode_rom.sv @@
// Microcode store: one control word for each program step.
`timescale 1ns / 1ps
module vsd_ucode_rom (
    input  vsd_pkg::step_t      pc,
    output vsd_pkg::ctrl_word_t cw
);

    always_comb
    begin
        cw = vsd_pkg::CW_NOP;
        unique case (pc)
            vsd_pkg::ST_IDLE:
            begin
                cw.load_in = 1'b1;
                cw.cond    = vsd_pkg::COND_IN_VALID;
                cw.target  = vsd_pkg::ST_SUB_OLD;
            end
            vsd_pkg::ST_SUB_OLD:
            begin
                cw.sub_old = 1'b1;
                cw.target  = vsd_pkg::ST_ADD_NEW;
            end
            vsd_pkg::ST_ADD_NEW:
            begin
                cw.add_new = 1'b1;
                cw.target  = vsd_pkg::ST_MUL0;
            end
            vsd_pkg::ST_MUL0:
            begin
                cw.mul_sel = vsd_pkg::MUL_VOL_LO;
                cw.target  = vsd_pkg::ST_MUL1;
            end
            vsd_pkg::ST_MUL1:
            begin
                cw.mul_sel = vsd_pkg::MUL_VOL_HI;
                cw.acc_op  = vsd_pkg::ACC_LHS_LOAD;
                cw.target  = vsd_pkg::ST_MUL2;
            end
            vsd_pkg::ST_MUL2:
            begin
                cw.mul_sel = vsd_pkg::MUL_SUM_LO;
                cw.acc_op  = vsd_pkg::ACC_LHS_ADD_HI;
                cw.target  = vsd_pkg::ST_MUL3;
            end
            vsd_pkg::ST_MUL3:
            begin
                cw.mul_sel = vsd_pkg::MUL_SUM_HI;
                cw.acc_op  = vsd_pkg::ACC_RHS_LOAD;
                cw.target  = vsd_pkg::ST_ACC;
            end
            vsd_pkg::ST_ACC:
            begin
                cw.acc_op   = vsd_pkg::ACC_RHS_ADD_HI;
                cw.div_init = 1'b1;
                cw.target   = vsd_pkg::ST_DIV;
            end
            vsd_pkg::ST_DIV:
            begin
                cw.div_step = 1'b1;
                cw.cond     = vsd_pkg::COND_DIV_LAST;
                cw.target   = vsd_pkg::ST_DONE;
            end
            vsd_pkg::ST_DONE:
            begin
                cw.out_load = 1'b1;
                cw.cond     = vsd_pkg::COND_OUT_FREE;
                cw.target   = vsd_pkg::ST_IDLE;
            end
            default:
            begin
                cw.target = vsd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/vsd_sequencer.sv @@
// Program counter with conditional jumps taken from the control word.
`timescale 1ns / 1ps
module vsd_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vsd_pkg::cond_t       cond,
    input  vsd_pkg::step_t       target,
    input  vsd_pkg::seq_status_t status,
    output vsd_pkg::step_t       pc
);

    vsd_pkg::step_t pc_reg;
    vsd_pkg::step_t pc_next;
    logic           cond_met;

    always_comb
    begin
        unique case (cond)
            vsd_pkg::COND_ALWAYS:   cond_met = 1'b1;
            vsd_pkg::COND_IN_VALID: cond_met = status.in_valid;
            vsd_pkg::COND_OUT_FREE: cond_met = status.out_free;
            vsd_pkg::COND_DIV_LAST: cond_met = status.div_last;
            default:                cond_met = 1'b1;
        endcase
        pc_next = cond_met ? target : pc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= vsd_pkg::ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        pc = pc_reg;
    end

endmodule

@@ design/vsd_datapath.sv @@
// Window state, shared multiplier, restoring divider and result register.
`timescale 1ns / 1ps
module vsd_datapath #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vsd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    input  logic [vsd_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  vsd_pkg::ctrl_word_t                 cw,
    output vsd_pkg::seq_status_t                status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [vsd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [vsd_pkg::OUT_TUSER_W-1:0]     m_tuser
);

    localparam int VOL_W    = vsd_pkg::VOL_W;
    localparam int STAMP_W  = vsd_pkg::STAMP_W;
    localparam int FACTOR_W = vsd_pkg::FACTOR_W;
    localparam int SLOT_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W    = VOL_W + SLOT_W;
    localparam int HALF_W   = (SUM_W + 1) / 2;
    localparam int PROD_W   = HALF_W + FACTOR_W;
    localparam int ACC_W    = SUM_W + FACTOR_W + 1;
    localparam int IT_W     = $clog2(SUM_W + 1);

    logic [vsd_pkg::WLEN_W-1:0] wlen_reg, wlen_next;
    logic [FACTOR_W-1:0]        factor_reg, factor_next;
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic [SLOT_W-1:0]          cur_slot_reg, cur_slot_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [STAMP_W-1:0]         stamp_reg, stamp_next;
    logic [VOL_W-1:0]           vol_reg, vol_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [ACC_W-1:0]           lhs_reg, lhs_next;
    logic [ACC_W-1:0]           rhs_reg, rhs_next;
    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic [SUM_W-1:0]           quo_reg, quo_next;
    logic [IT_W-1:0]            iter_reg, iter_next;
    logic                       out_valid_reg, out_valid_next;
    logic [STAMP_W-1:0]         out_stamp_reg, out_stamp_next;
    logic [VOL_W-1:0]           out_vol_reg, out_vol_next;
    logic [VOL_W-1:0]           out_mean_reg, out_mean_next;
    logic                       out_full_reg, out_full_next;
    logic                       out_spike_reg, out_spike_next;

    logic [CNT_W-1:0]  len;
    logic [SLOT_W-1:0] slot_eff;
    logic [SLOT_W:0]   slot_inc;
    logic              in_fire;
    logic              out_free;
    logic [VOL_W-1:0]  rd_data;
    logic [HALF_W-1:0] mul_a;
    logic [FACTOR_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_res;
    logic [ACC_W-1:0]  prod_hi;
    logic [ACC_W-1:0]  lhs_cmp;
    logic [CNT_W:0]    div_shift;
    logic [CNT_W:0]    div_diff;
    logic              div_ge;
    logic              full;

    vsd_ring #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (VOL_W)
    ) u_ring (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (slot_eff),
        .rd_data (rd_data),
        .wr_en   (cw.add_new),
        .wr_addr (cur_slot_reg),
        .wr_data (vol_reg)
    );

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len = CNT_W'(1);
        end
        else if (32'(wlen_reg) > MAX_WINDOW)
        begin
            len = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            len = CNT_W'(wlen_reg);
        end
        slot_eff = (32'(slot_reg) >= 32'(len)) ? '0 : slot_reg;
        slot_inc = {1'b0, cur_slot_reg} + (SLOT_W + 1)'(1);
        in_fire  = cw.load_in && s_tvalid;
        out_free = !out_valid_reg || m_tready;

        case (cw.mul_sel)
            vsd_pkg::MUL_VOL_LO:
            begin
                mul_a = vol_reg[HALF_W-1:0];
                mul_b = FACTOR_W'(count_reg);
            end
            vsd_pkg::MUL_VOL_HI:
            begin
                mul_a = HALF_W'(vol_reg >> HALF_W);
                mul_b = FACTOR_W'(count_reg);
            end
            vsd_pkg::MUL_SUM_LO:
            begin
                mul_a = sum_reg[HALF_W-1:0];
                mul_b = factor_reg;
            end
            vsd_pkg::MUL_SUM_HI:
            begin
                mul_a = HALF_W'(sum_reg >> HALF_W);
                mul_b = factor_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);
        prod_hi = ACC_W'(prod_reg) << HALF_W;
        lhs_cmp = lhs_reg << 8;
        full    = (count_reg == len);

        div_shift = {rem_reg, quo_reg[SUM_W-1]};
        div_ge    = (div_shift >= {1'b0, count_reg});
        div_diff  = div_shift - {1'b0, count_reg};
    end

    always_comb
    begin
        wlen_next      = wlen_reg;
        factor_next    = factor_reg;
        slot_next      = slot_reg;
        cur_slot_next  = cur_slot_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        stamp_next     = stamp_reg;
        vol_next       = vol_reg;
        prod_next      = prod_reg;
        lhs_next       = lhs_reg;
        rhs_next       = rhs_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg;
        out_stamp_next = out_stamp_reg;
        out_vol_next   = out_vol_reg;
        out_mean_next  = out_mean_reg;
        out_full_next  = out_full_reg;
        out_spike_next = out_spike_reg;

        // Writing the window length empties the window.
        if (cfg_we)
        begin
            if (cfg_index == vsd_pkg::CFG_WINDOW_LENGTH)
            begin
                wlen_next  = cfg_data[vsd_pkg::WLEN_W-1:0];
                slot_next  = '0;
                count_next = '0;
                sum_next   = '0;
            end
            else if (cfg_index == vsd_pkg::CFG_SPIKE_FACTOR)
            begin
                factor_next = cfg_data[FACTOR_W-1:0];
            end
        end

        if (in_fire)
        begin
            stamp_next    = s_tdata[STAMP_W-1:0];
            vol_next      = s_tdata[STAMP_W+VOL_W-1:STAMP_W];
            cur_slot_next = slot_eff;
        end

        if (cw.sub_old)
        begin
            if (count_reg >= len)
            begin
                sum_next   = sum_reg - SUM_W'(rd_data);
                count_next = len;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (cw.add_new)
        begin
            sum_next  = sum_reg + SUM_W'(vol_reg);
            slot_next = (32'(slot_inc) >= 32'(len)) ? '0 : slot_inc[SLOT_W-1:0];
        end

        if (cw.mul_sel != vsd_pkg::MUL_NONE)
        begin
            prod_next = mul_res;
        end

        case (cw.acc_op)
            vsd_pkg::ACC_LHS_LOAD:   lhs_next = ACC_W'(prod_reg);
            vsd_pkg::ACC_LHS_ADD_HI: lhs_next = lhs_reg + prod_hi;
            vsd_pkg::ACC_RHS_LOAD:   rhs_next = ACC_W'(prod_reg);
            vsd_pkg::ACC_RHS_ADD_HI: rhs_next = rhs_reg + prod_hi;
            default:                 ;
        endcase

        if (cw.div_init)
        begin
            rem_next  = '0;
            quo_next  = sum_reg;
            iter_next = IT_W'(SUM_W);
        end
        else if (cw.div_step)
        begin
            rem_next  = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], div_ge};
            iter_next = iter_reg - IT_W'(1);
        end

        if (cw.out_load && out_free)
        begin
            out_valid_next = 1'b1;
            out_stamp_next = stamp_reg;
            out_vol_next   = vol_reg;
            out_mean_next  = quo_reg[VOL_W-1:0];
            out_full_next  = full;
            out_spike_next = full && (lhs_cmp > rhs_reg);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= vsd_pkg::WLEN_RESET;
            factor_reg    <= vsd_pkg::FACTOR_RESET;
            slot_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wlen_reg      <= wlen_next;
            factor_reg    <= factor_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_slot_reg  <= cur_slot_next;
        stamp_reg     <= stamp_next;
        vol_reg       <= vol_next;
        prod_reg      <= prod_next;
        lhs_reg       <= lhs_next;
        rhs_reg       <= rhs_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        out_stamp_reg <= out_stamp_next;
        out_vol_reg   <= out_vol_next;
        out_mean_reg  <= out_mean_next;
        out_full_reg  <= out_full_next;
        out_spike_reg <= out_spike_next;
    end

    assign status.in_valid = s_tvalid;
    assign status.out_free = out_free;
    assign status.div_last = (iter_reg == IT_W'(1));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = vsd_pkg::OUT_TDATA_W'({out_mean_reg, out_vol_reg, out_stamp_reg});
    assign m_tuser  = {out_spike_reg, out_full_reg};

endmodule

@@ design/volume_spike_detector_top.sv @@
// Top level of the volume spike detector.
//
// One trade record enters on the slave stream; each record gives exactly one
// result on the master stream: the timestamp and volume echoed, the truncated
// mean of the held volumes, a window full flag and a spike flag.
// A short microprogram runs each record: two steps update the window sum
// and fill count, four steps drive the shared multiplier for the exact spike
// test, one step finishes the products, 52 steps run the radix-2 divider for
// the mean (one quotient bit a step), and one step loads the result register.
// A new record is taken only when the program is back in its first step,
// after the last result is loaded; the divider loop takes the most steps.
// A finished result waits in its own register, so the next record may enter
// while the receiver holds tready low; the program only stalls in its last
// step when a result is still waiting there.
// Reset sets the window length to 10, the factor to 2.0 and empties the
// window. Register writes are taken at any edge with cfg_we high; writing the
// window length empties the window.
`timescale 1ns / 1ps
`include "volume_spike_detector_top_defines.svh"
module volume_spike_detector_top #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vsd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // stamp_ns, trade_volume
    input  logic [vsd_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // stamp_out, volume_out, mean_volume
    output logic [vsd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // window_full, spike_flag
    output logic [vsd_pkg::OUT_TUSER_W-1:0]     m_tuser
);

    vsd_pkg::step_t       pc;
    vsd_pkg::ctrl_word_t  cw;
    vsd_pkg::seq_status_t status;

    vsd_ucode_rom u_rom (
        .pc (pc),
        .cw (cw)
    );

    vsd_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cond   (cw.cond),
        .target (cw.target),
        .status (status),
        .pc     (pc)
    );

    vsd_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .cw        (cw),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    assign s_tready = cw.load_in;

    `VSD_ASSERT_NEXT(a_accept_starts_program, s_tvalid && s_tready, pc == vsd_pkg::ST_SUB_OLD, "transfer in did not start the update steps")
    `VSD_ASSERT_IMP(a_result_from_last_step, $rose(m_tvalid), $past(pc) == vsd_pkg::ST_DONE, "result appeared outside the final step")
    `VSD_ASSERT_NEXT(a_done_loads_result, pc == vsd_pkg::ST_DONE && status.out_free, m_tvalid && pc == vsd_pkg::ST_IDLE, "final step did not hand over the result")

endmodule

@@ sim/tb_volume_spike_detector_top.sv @@
// Self-checking testbench for the volume spike detector: directed and random trade records.
`timescale 1ns / 1ps
module tb_volume_spike_detector_top;

    localparam int DEPTH         = 16;
    localparam int SUM_W         = 52;
    localparam int CYCLE_LIMIT   = 900000;
    localparam int SEGMENT_ITEMS = 103;
    localparam int TAIL_CYCLES   = 80;
    localparam int SEG_WLEN[8]   = '{16, 1, 31, 5, 0, 9, 3, 24};
    localparam int SEG_FACTOR[8] = '{512, 200, 384, 0, 300, 65535, 1, 256};

    typedef struct packed {
        logic [vsd_pkg::STAMP_W-1:0] stamp;
        logic [vsd_pkg::VOL_W-1:0]   volume;
    } trade_record_t;

    typedef struct packed {
        logic [vsd_pkg::STAMP_W-1:0] stamp;
        logic [vsd_pkg::VOL_W-1:0]   volume;
        logic [vsd_pkg::VOL_W-1:0]   mean;
        logic                        full;
        logic                        spike;
    } window_stats_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [vsd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [vsd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [vsd_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [vsd_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [vsd_pkg::OUT_TUSER_W-1:0] m_tuser;

    trade_record_t record_queue[$];
    window_stats_t predicted_stats[$];

    logic [vsd_pkg::VOL_W-1:0]    held_volumes[DEPTH];
    logic [vsd_pkg::WLEN_W-1:0]   model_wlen;
    logic [vsd_pkg::FACTOR_W-1:0] model_factor;
    int                           model_slot;
    int                           model_fill;
    logic [SUM_W-1:0]             model_sum;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int issued_n      = 0;
    int accepted_n    = 0;
    int result_n      = 0;
    int full_n        = 0;
    int spike_n       = 0;
    int write_n       = 0;
    int mismatch_n    = 0;
    int cycle_n       = 0;

    volume_spike_detector_top #(
        .MAX_WINDOW (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic clear_window();
        for (int i = 0; i < DEPTH; i++)
            held_volumes[i] = '0;
        model_slot = 0;
        model_fill = 0;
        model_sum  = '0;
    endtask

    task automatic advance_window(input logic [vsd_pkg::STAMP_W-1:0] stamp,
                                  input logic [vsd_pkg::VOL_W-1:0] vol);
        int            len;
        int            pos;
        logic [71:0]   lhs;
        logic [71:0]   rhs;
        window_stats_t res;
        len = (model_wlen == 0) ? 1 : ((model_wlen > DEPTH) ? DEPTH : int'(model_wlen));
        pos = (model_slot >= len) ? 0 : model_slot;
        if (model_fill >= len)
        begin
            model_sum  = model_sum - SUM_W'(held_volumes[pos]);
            model_fill = len;
        end
        else
            model_fill = model_fill + 1;
        held_volumes[pos] = vol;
        model_sum  = model_sum + SUM_W'(vol);
        model_slot = (pos + 1 >= len) ? 0 : pos + 1;
        res.stamp  = stamp;
        res.volume = vol;
        res.mean   = vsd_pkg::VOL_W'(model_sum / SUM_W'(model_fill));
        res.full   = (model_fill == len);
        // Exact form of volume > mean * factor, with the factor in Q8.8.
        lhs        = 72'(vol) * 72'(model_fill * 256);
        rhs        = 72'(model_sum) * 72'(model_factor);
        res.spike  = res.full && (lhs > rhs);
        predicted_stats.insert(predicted_stats.size(), res);
    endtask

    task automatic flag_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_n++;
        if (mismatch_n <= 40)
            $display("[cycle %0d] %s differs: got 0x%0h, expected 0x%0h",
                     cycle_n, field, got, want);
    endtask

    task automatic write_register(input logic [vsd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [vsd_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == vsd_pkg::CFG_WINDOW_LENGTH)
        begin
            model_wlen = value[vsd_pkg::WLEN_W-1:0];
            clear_window();
        end
        else
            model_factor = value;
        write_n++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_record(input logic [vsd_pkg::STAMP_W-1:0] stamp,
                                input logic [vsd_pkg::VOL_W-1:0] vol);
        trade_record_t rec;
        rec.stamp  = stamp;
        rec.volume = vol;
        record_queue.insert(record_queue.size(), rec);
    endtask

    // Returns once every queued record has been taken and every result has arrived.
    task automatic settle();
        while (record_queue.size() != 0 || issued_n != accepted_n || predicted_stats.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [vsd_pkg::STAMP_W-1:0] rand_stamp();
        return vsd_pkg::STAMP_W'({$urandom, $urandom});
    endfunction

    always @(negedge clk)
    begin : record_driver
        trade_record_t rec;
        if (rst_n && (!s_tvalid || issued_n == accepted_n))
        begin
            if (record_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                rec = record_queue[0];
                record_queue.delete(0);
                s_tdata  <= {{(vsd_pkg::IN_TDATA_W - vsd_pkg::STAMP_W - vsd_pkg::VOL_W){1'b0}},
                             rec.volume, rec.stamp};
                s_tvalid <= 1'b1;
                issued_n <= issued_n + 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            advance_window(s_tdata[vsd_pkg::STAMP_W-1:0],
                           s_tdata[vsd_pkg::STAMP_W +: vsd_pkg::VOL_W]);
            accepted_n <= accepted_n + 1;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        window_stats_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_n++;
            if (m_tuser[0])
                full_n++;
            if (m_tuser[1])
                spike_n++;
            if (predicted_stats.size() == 0)
                flag_mismatch("unexpected transfer, stamp_out",
                              64'(m_tdata[vsd_pkg::STAMP_W-1:0]), 64'd0);
            else
            begin
                want = predicted_stats[0];
                predicted_stats.delete(0);
                if (m_tdata[vsd_pkg::STAMP_W-1:0] != want.stamp)
                    flag_mismatch("stamp_out", 64'(m_tdata[vsd_pkg::STAMP_W-1:0]),
                                  64'(want.stamp));
                if (m_tdata[vsd_pkg::STAMP_W +: vsd_pkg::VOL_W] != want.volume)
                    flag_mismatch("volume_out",
                                  64'(m_tdata[vsd_pkg::STAMP_W +: vsd_pkg::VOL_W]),
                                  64'(want.volume));
                if (m_tdata[vsd_pkg::STAMP_W + vsd_pkg::VOL_W +: vsd_pkg::VOL_W] != want.mean)
                    flag_mismatch("mean_volume",
                        64'(m_tdata[vsd_pkg::STAMP_W + vsd_pkg::VOL_W +: vsd_pkg::VOL_W]),
                        64'(want.mean));
                if (m_tuser[0] != want.full)
                    flag_mismatch("window_full", 64'(m_tuser[0]), 64'(want.full));
                if (m_tuser[1] != want.spike)
                    flag_mismatch("spike_flag", 64'(m_tuser[1]), 64'(want.spike));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n > CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results still awaited.",
                     predicted_stats.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [vsd_pkg::VOL_W-1:0] base;
        logic [vsd_pkg::VOL_W-1:0] vol;
        int                        pick;
        model_wlen   = vsd_pkg::WLEN_RESET;
        model_factor = vsd_pkg::FACTOR_RESET;
        clear_window();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 11;
        recv_idle_pct = 86;

        queue_record('0, '0);
        queue_record('1, '1);
        queue_record(rand_stamp(), 48'd1);
        settle();

        // A window of one with a zero factor flags every non-zero volume.
        write_register(vsd_pkg::CFG_WINDOW_LENGTH, {11'($urandom), 5'd1});
        write_register(vsd_pkg::CFG_SPIKE_FACTOR, 16'd0);
        queue_record(rand_stamp(), '0);
        queue_record(rand_stamp(), 48'd1);
        queue_record(rand_stamp(), '1);
        settle();
        write_register(vsd_pkg::CFG_SPIKE_FACTOR, 16'd255);
        queue_record(rand_stamp(), '1);
        settle();
        write_register(vsd_pkg::CFG_SPIKE_FACTOR, 16'd256);
        queue_record(rand_stamp(), '1);
        settle();

        // A length of zero behaves as a length of one.
        write_register(vsd_pkg::CFG_WINDOW_LENGTH, {11'($urandom), 5'd0});
        queue_record(rand_stamp(), 48'd7);
        queue_record(rand_stamp(), '1);
        settle();

        write_register(vsd_pkg::CFG_WINDOW_LENGTH, 16'd2);
        write_register(vsd_pkg::CFG_SPIKE_FACTOR, 16'd65535);
        queue_record(rand_stamp(), '0);
        queue_record(rand_stamp(), '1);
        queue_record(rand_stamp(), '1);
        settle();
        // Rewriting the same length still empties the window.
        write_register(vsd_pkg::CFG_WINDOW_LENGTH, 16'd2);
        queue_record(rand_stamp(), 48'd3);
        queue_record(rand_stamp(), 48'd5);
        settle();

        write_register(vsd_pkg::CFG_WINDOW_LENGTH, {11'($urandom), 5'd31});
        write_register(vsd_pkg::CFG_SPIKE_FACTOR, 16'd1);
        queue_record(rand_stamp(), '1);
        queue_record(rand_stamp(), 48'd1);
        queue_record(rand_stamp(), '0);
        settle();

        for (int seg = 0; seg < 8; seg++)
        begin
            if (seg == 3)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 11;
            end
            if (seg == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_register(vsd_pkg::CFG_WINDOW_LENGTH, {11'($urandom), 5'(SEG_WLEN[seg])});
            write_register(vsd_pkg::CFG_SPIKE_FACTOR, 16'(SEG_FACTOR[seg]));
            for (int half = 0; half < 2; half++)
            begin
                // A factor change keeps the window contents.
                if (half == 1)
                    write_register(vsd_pkg::CFG_SPIKE_FACTOR, 16'($urandom_range(0, 1023)));
                base = vsd_pkg::VOL_W'({$urandom, $urandom}) >> $urandom_range(8, 47);
                for (int n = 0; n < SEGMENT_ITEMS; n++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        vol = vsd_pkg::VOL_W'({$urandom, $urandom});
                    else if (pick < 10)
                        vol = '0;
                    else if (pick < 12)
                        vol = '1;
                    else if (pick < 86)
                        vol = base + vsd_pkg::VOL_W'({$urandom, $urandom} %
                                                     (64'(base) / 2 + 1));
                    else
                        vol = base * vsd_pkg::VOL_W'($urandom_range(2, 40));
                    queue_record(rand_stamp(), vol);
                end
                settle();
            end
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Checked %0d results for %0d records across %0d register writes.",
                 result_n, accepted_n, write_n);
        $display("Results with a full window: %0d, spikes flagged: %0d.", full_n, spike_n);
        if (mismatch_n == 0 && predicted_stats.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
